/* rtl/core/accumulator_machine_executor_unit_assert.svh */
// Assertion macros shared by the accumulator machine executor RTL.
`ifndef ACCUMULATOR_MACHINE_EXECUTOR_UNIT_ASSERT_SVH
`define ACCUMULATOR_MACHINE_EXECUTOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, clocked on i_clk, off while in reset
`define AME_CHECK_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, clocked on i_clk, off while in reset
`define AME_CHECK_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define AME_CHECK_NOW(name, ante, cons, msg)
`define AME_CHECK_NEXT(name, ante, cons, msg)
`endif

`endif

/* rtl/core/ame_pkg.sv */
// Shared types and constants of the accumulator machine executor.
package ame_pkg;

    // Storage and field geometry
    localparam int MEMORY_WORDS = 100;
    localparam int ADDR_BITS    = 7;
    localparam int INSTR_BITS   = 14;
    localparam int FIELD_BITS   = 7;
    localparam int ENTRY_BITS   = 32;

    // Divide-by-100 via reciprocal: q = (instr * 5243) >> 19, exact for 14-bit inputs
    localparam int              DEC_BASE    = 100;
    localparam int              RECIP_BITS  = 13;
    localparam logic [12:0]     DEC_RECIP   = 13'd5243;
    localparam int              DEC_SHIFT   = 19;
    localparam int              PROD_BITS   = INSTR_BITS + RECIP_BITS;
    localparam int              QUOT_BITS   = PROD_BITS - DEC_SHIFT;
    localparam int              OPCODE_LAST = 99;

    // Opcodes
    localparam logic [FIELD_BITS-1:0] OP_READ    = 7'd10;
    localparam logic [FIELD_BITS-1:0] OP_WRITE   = 7'd11;
    localparam logic [FIELD_BITS-1:0] OP_LOAD    = 7'd20;
    localparam logic [FIELD_BITS-1:0] OP_STORE   = 7'd21;
    localparam logic [FIELD_BITS-1:0] OP_ADD     = 7'd30;
    localparam logic [FIELD_BITS-1:0] OP_SUB     = 7'd31;
    localparam logic [FIELD_BITS-1:0] OP_DIVIDE  = 7'd32;
    localparam logic [FIELD_BITS-1:0] OP_MULT    = 7'd33;
    localparam logic [FIELD_BITS-1:0] OP_CLEAR   = 7'd43;
    localparam logic [FIELD_BITS-1:0] OP_INVALID = 7'd127;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_BAD_OP   = 2'd1,
        STS_DIV_ZERO = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV100,
        ST_SPLIT,
        ST_READ,
        ST_EXEC,
        ST_ITER,
        ST_FINISH
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic div100;
        logic split;
        logic read;
        logic exec;
        logic iter_take;
        logic commit;
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic needs_iter;
        logic iter_done;
        logic out_free;
    } t_dp_sts;

endpackage

/* rtl/core/ame_channels.sv */
// Handshake channel interfaces for instruction input and execution results.
interface ame_in_if import ame_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic        [INSTR_BITS-1:0] instruction;
    logic signed [ENTRY_BITS-1:0] entered_word;

    modport source (output valid, instruction, entered_word, input ready);
    modport sink   (input valid, instruction, entered_word, output ready);
endinterface

interface ame_out_if import ame_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic        [FIELD_BITS-1:0] opcode;
    logic        [FIELD_BITS-1:0] address;
    logic signed [ENTRY_BITS-1:0] accumulator_value;
    logic signed [ENTRY_BITS-1:0] addressed_word;
    logic                         write_out;
    logic                  [1:0]  status;

    modport source (output valid, opcode, address, accumulator_value, addressed_word,
                    write_out, status, input ready);
    modport sink   (input valid, opcode, address, accumulator_value, addressed_word,
                    write_out, status, output ready);
endinterface

/* rtl/core/accumulator_machine_executor_unit.sv */
// Accumulator machine executor: top level joining controller and datapath.
//
// Input channel i_in carries one four-digit decimal instruction and an entered
// data word per transfer; output channel o_out returns one result per instruction:
// decoded opcode and address, accumulator after execution, the addressed memory
// word after execution, an output flag and a status code.
// Each instruction passes through capture, divide-by-100, split, memory read and
// execute; multiply and divide by a nonzero word then wait for the iterative unit.
// A new instruction is taken only once the previous one has committed; the shared
// multiply/divide unit retires one bit per cycle.
// Reset (synchronous, active low) clears the accumulator and marks every memory
// word as zero through per-word valid bits; the block is ready the cycle after.
// Results sit in an output register: the next instruction is taken while a
// result waits, and only its hand-off stalls until the receiver takes the result.
module accumulator_machine_executor_unit import ame_pkg::*; #(
    parameter int WORD_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ame_in_if.sink    i_in,
    ame_out_if.source o_out
);
    t_ctrl_cmd w_cmd;
    t_dp_sts   w_sts;
    logic      w_in_ready;

    // Sequencer
    ame_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Datapath
    ame_dp #(
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_instruction  (i_in.instruction),
        .i_entered_word (i_in.entered_word),
        .o_out          (o_out)
    );

    assign i_in.ready = w_in_ready;

endmodule

/* rtl/core/ame_muldiv.sv */
// Bit-serial multiplier and truncating signed divider, one bit per cycle.
module ame_muldiv #(
    parameter int WORD_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_divide,
    input  logic [WORD_BITS-1:0] i_a,
    input  logic [WORD_BITS-1:0] i_b,
    output logic                 o_done,
    output logic [WORD_BITS-1:0] o_result
);
    localparam int CNT_BITS = $clog2(WORD_BITS + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_BITS-1:0]  r_cnt;
    logic                 r_div;
    logic                 r_neg;
    logic [WORD_BITS-1:0] r_a;
    logic [WORD_BITS-1:0] r_b;
    logic [WORD_BITS-1:0] r_p;
    logic [WORD_BITS-1:0] r_rem;

    logic [WORD_BITS-1:0] w_mag_a;
    logic [WORD_BITS-1:0] w_mag_b;
    logic [WORD_BITS:0]   w_rem_sh;
    logic [WORD_BITS:0]   w_diff;

    // Operand magnitudes for the divider
    assign w_mag_a = i_a[WORD_BITS-1] ? ('0 - i_a) : i_a;
    assign w_mag_b = i_b[WORD_BITS-1] ? ('0 - i_b) : i_b;

    // Restoring step: shift in next dividend bit, trial subtract
    assign w_rem_sh = {r_rem, r_a[WORD_BITS-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_b};

    // Step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_BITS'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(WORD_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Shift-add multiply / shift-subtract divide
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divide;
            r_neg <= i_a[WORD_BITS-1] ^ i_b[WORD_BITS-1];
            r_a   <= i_divide ? w_mag_a : i_a;
            r_b   <= i_divide ? w_mag_b : i_b;
            r_p   <= '0;
            r_rem <= '0;
        end else if (r_busy) begin
            r_a <= r_a << 1;
            if (r_div) begin
                r_rem <= w_diff[WORD_BITS] ? w_rem_sh[WORD_BITS-1:0] : w_diff[WORD_BITS-1:0];
                r_p   <= {r_p[WORD_BITS-2:0], ~w_diff[WORD_BITS]};
            end else begin
                r_b <= r_b >> 1;
                if (r_b[0]) begin
                    r_p <= r_p + r_a;
                end
            end
        end
    end

    // Quotient sign fix-up; wraps for most negative over minus one
    assign o_result = (r_div && r_neg) ? ('0 - r_p) : r_p;
    assign o_done   = r_done;

endmodule

/* rtl/core/ame_ctrl.sv */
// Sequencing state machine: decode, memory read, execute, result hand-off.
`include "accumulator_machine_executor_unit_assert.svh"

module ame_ctrl import ame_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_dp_sts   i_sts,
    output t_ctrl_cmd o_cmd
);
    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_DIV100;
                end
            end
            ST_DIV100: begin
                o_cmd.div100 = 1'b1;
                n_state      = ST_SPLIT;
            end
            ST_SPLIT: begin
                o_cmd.split = 1'b1;
                n_state     = ST_READ;
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
                n_state    = ST_EXEC;
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.needs_iter ? ST_ITER : ST_FINISH;
            end
            ST_ITER: begin
                if (i_sts.iter_done) begin
                    o_cmd.iter_take = 1'b1;
                    n_state         = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // wait for the result register to free up
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `AME_CHECK_NEXT(a_accept_starts_decode, o_cmd.capture, r_state == ST_DIV100, "accept did not start decode")
    `AME_CHECK_NOW(a_iter_done_in_iter, i_sts.iter_done, r_state == ST_ITER, "iterative unit done outside wait")
    `AME_CHECK_NEXT(a_simple_op_finishes, o_cmd.exec && !i_sts.needs_iter, r_state == ST_FINISH, "simple op did not finish")

endmodule

/* rtl/core/ame_dp.sv */
// Datapath: decimal decode, accumulator, data memory, execute and result register.
`include "accumulator_machine_executor_unit_assert.svh"

module ame_dp import ame_pkg::*; #(
    parameter int WORD_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_ctrl_cmd                    i_cmd,
    output t_dp_sts                      o_sts,
    input  logic        [INSTR_BITS-1:0] i_instruction,
    input  logic signed [ENTRY_BITS-1:0] i_entered_word,
    ame_out_if.source                    o_out
);
    // Item registers
    logic [INSTR_BITS-1:0] r_instr;
    logic [WORD_BITS-1:0]  r_entered;
    logic [QUOT_BITS-1:0]  r_quot;
    logic [FIELD_BITS-1:0] r_opcode;
    logic [ADDR_BITS-1:0]  r_addr;
    logic [WORD_BITS-1:0]  r_rd_data;
    logic                  r_rd_vld;

    // Architectural state
    logic [WORD_BITS-1:0]    r_acc;
    logic [WORD_BITS-1:0]    r_mem [MEMORY_WORDS];
    logic [MEMORY_WORDS-1:0] r_vld;

    // Execute results
    logic [WORD_BITS-1:0] r_new_acc;
    logic                 r_mem_we;
    logic [WORD_BITS-1:0] r_mem_wd;
    logic                 r_wr;
    t_status              r_status;
    logic [WORD_BITS-1:0] n_new_acc;
    logic                 n_mem_we;
    logic [WORD_BITS-1:0] n_mem_wd;
    logic                 n_wr;
    t_status              n_status;

    // Result register
    logic                  r_out_valid;
    logic [FIELD_BITS-1:0] r_out_opcode;
    logic [FIELD_BITS-1:0] r_out_addr;
    logic [ENTRY_BITS-1:0] r_out_acc;
    logic [ENTRY_BITS-1:0] r_out_word;
    logic                  r_out_wr;
    t_status               r_out_status;

    logic [PROD_BITS-1:0]  w_recip_prod;
    logic [INSTR_BITS-1:0] w_hundreds;
    logic [INSTR_BITS-1:0] w_rem;
    logic [WORD_BITS-1:0]  w_operand;
    logic                  w_needs_iter;
    logic                  w_iter_div;
    logic                  w_iter_done;
    logic [WORD_BITS-1:0]  w_iter_result;
    logic                  w_out_free;

    // Input capture; entered word sign-extended or truncated to the word width
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_instr   <= i_instruction;
            r_entered <= WORD_BITS'(i_entered_word);
        end
    end

    // Decode: quotient by reciprocal, then remainder
    assign w_recip_prod = PROD_BITS'(r_instr) * PROD_BITS'(DEC_RECIP);
    assign w_hundreds   = INSTR_BITS'(r_quot) * INSTR_BITS'(DEC_BASE);
    assign w_rem        = r_instr - w_hundreds;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div100) begin
            r_quot <= w_recip_prod[DEC_SHIFT +: QUOT_BITS];
        end
        if (i_cmd.split) begin
            r_addr   <= w_rem[ADDR_BITS-1:0];
            r_opcode <= (r_quot > QUOT_BITS'(OPCODE_LAST)) ? OP_INVALID
                                                           : r_quot[FIELD_BITS-1:0];
        end
    end

    // Data memory: registered read, write at commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd_data <= r_mem[r_addr];
        end
        if (i_cmd.commit && r_mem_we) begin
            r_mem[r_addr] <= r_mem_wd;
        end
    end

    // Per-word valid bits stand in for the cleared memory
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.read) begin
                r_rd_vld <= r_vld[r_addr];
            end
            if (i_cmd.commit && r_mem_we) begin
                r_vld[r_addr] <= 1'b1;
            end
        end
    end

    assign w_operand = r_rd_vld ? r_rd_data : '0;

    // Execute decode
    always_comb begin
        n_new_acc    = r_acc;
        n_mem_we     = 1'b0;
        n_mem_wd     = r_acc;
        n_wr         = 1'b0;
        n_status     = STS_OK;
        w_needs_iter = 1'b0;
        w_iter_div   = 1'b0;
        unique case (r_opcode)
            OP_READ: begin
                n_mem_we = 1'b1;
                n_mem_wd = r_entered;
            end
            OP_WRITE: begin
                n_wr = 1'b1;
            end
            OP_LOAD: begin
                n_new_acc = w_operand;
            end
            OP_STORE: begin
                n_mem_we  = 1'b1;
                n_new_acc = '0;
            end
            OP_ADD: begin
                n_new_acc = r_acc + w_operand;
            end
            OP_SUB: begin
                n_new_acc = r_acc - w_operand;
            end
            OP_DIVIDE: begin
                // zero divisor: report, accumulator kept
                if (w_operand == '0) begin
                    n_status = STS_DIV_ZERO;
                end else begin
                    w_needs_iter = 1'b1;
                    w_iter_div   = 1'b1;
                end
            end
            OP_MULT: begin
                w_needs_iter = 1'b1;
            end
            OP_CLEAR: begin
                n_new_acc = '0;
            end
            default: begin
                n_status = STS_BAD_OP;
            end
        endcase
    end

    ame_muldiv #(
        .WORD_BITS (WORD_BITS)
    ) u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.exec && w_needs_iter),
        .i_divide (w_iter_div),
        .i_a      (r_acc),
        .i_b      (w_operand),
        .o_done   (w_iter_done),
        .o_result (w_iter_result)
    );

    // Execute result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_new_acc <= n_new_acc;
            r_mem_we  <= n_mem_we;
            r_mem_wd  <= n_mem_wd;
            r_wr      <= n_wr;
            r_status  <= n_status;
        end else if (i_cmd.iter_take) begin
            r_new_acc <= w_iter_result;
        end
    end

    // Accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_cmd.commit) begin
            r_acc <= r_new_acc;
        end
    end

    // Result register and its transfer handshake
    assign w_out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_opcode <= r_opcode;
            r_out_addr   <= r_addr;
            r_out_acc    <= ENTRY_BITS'(r_new_acc);
            r_out_word   <= r_mem_we ? ENTRY_BITS'(r_mem_wd) : ENTRY_BITS'(w_operand);
            r_out_wr     <= r_wr;
            r_out_status <= r_status;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.opcode            = r_out_opcode;
    assign o_out.address           = r_out_addr;
    assign o_out.accumulator_value = r_out_acc;
    assign o_out.addressed_word    = r_out_word;
    assign o_out.write_out         = r_out_wr;
    assign o_out.status            = r_out_status;

    assign o_sts.needs_iter = w_needs_iter;
    assign o_sts.iter_done  = w_iter_done;
    assign o_sts.out_free   = w_out_free;

    `AME_CHECK_NOW(a_write_flag_opcode, o_out.valid && o_out.write_out, o_out.opcode == OP_WRITE, "write flag on wrong opcode")
    `AME_CHECK_NOW(a_div_zero_opcode, o_out.valid && (o_out.status == STS_DIV_ZERO), o_out.opcode == OP_DIVIDE, "divide status on wrong opcode")
    `AME_CHECK_NEXT(a_addr_in_range, i_cmd.split, r_addr < ADDR_BITS'(MEMORY_WORDS), "decoded address out of range")

endmodule

/* sim/accumulator_machine_executor_unit_tb.sv */
// Self-checking testbench for the accumulator machine executor: random and directed programs.
module accumulator_machine_executor_unit_tb;
    import ame_pkg::*;

    // One execution result as seen on the output channel
    typedef struct packed {
        logic [FIELD_BITS-1:0] opcode;
        logic [FIELD_BITS-1:0] address;
        logic [ENTRY_BITS-1:0] accumulator_value;
        logic [ENTRY_BITS-1:0] addressed_word;
        logic                  write_out;
        t_status               status;
    } t_exec_result;

    // Machine state model plus the queue of results still owed by the block
    class ame_result_board;
        logic signed [ENTRY_BITS-1:0] accum;
        logic signed [ENTRY_BITS-1:0] data_mem [MEMORY_WORDS];
        t_exec_result                 owed_results [$];
        int                           mismatches;

        function new();
            accum = '0;
            foreach (data_mem[i]) data_mem[i] = '0;
            mismatches = 0;
        endfunction

        // Execute one accepted instruction and queue the result it must produce
        function void note_instruction(logic [INSTR_BITS-1:0] instr,
                                       logic [ENTRY_BITS-1:0] word);
            int unsigned                  op_num;
            int unsigned                  addr;
            logic signed [ENTRY_BITS-1:0] operand;
            longint                       quot;
            t_exec_result                 res;
            op_num = instr / DEC_BASE;
            addr = instr % DEC_BASE;
            operand = data_mem[addr];
            res.write_out = 1'b0;
            res.status = STS_OK;
            if (op_num > OPCODE_LAST) begin
                res.opcode = OP_INVALID;
                res.status = STS_BAD_OP;
            end else begin
                res.opcode = FIELD_BITS'(op_num);
                case (res.opcode)
                    OP_READ:   data_mem[addr] = word;
                    OP_WRITE:  res.write_out = 1'b1;
                    OP_LOAD:   accum = operand;
                    OP_STORE: begin
                        data_mem[addr] = accum;
                        accum = '0;
                    end
                    OP_ADD:    accum = accum + operand;
                    OP_SUB:    accum = accum - operand;
                    OP_DIVIDE: begin
                        // zero divisor leaves the accumulator alone
                        if (operand == 0) begin
                            res.status = STS_DIV_ZERO;
                        end else begin
                            // 64-bit quotient keeps min / -1 well defined, then wrap
                            quot = longint'(accum) / longint'(operand);
                            accum = quot[ENTRY_BITS-1:0];
                        end
                    end
                    OP_MULT:   accum = accum * operand;
                    OP_CLEAR:  accum = '0;
                    default:   res.status = STS_BAD_OP;
                endcase
            end
            res.address = FIELD_BITS'(addr);
            res.accumulator_value = accum;
            res.addressed_word = data_mem[addr];
            owed_results.push_back(res);
        endfunction

        // Compare one accepted result with the oldest owed one
        function void check_result(t_exec_result got);
            t_exec_result want;
            if (owed_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing owed: op %0d addr %0d", $realtime,
                             got.opcode, got.address);
                return;
            end
            want = owed_results.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: mismatch op/addr/acc/word/wr/sts", $realtime);
                    $display("  want %0d %0d %0d %0d %0d %0d", want.opcode, want.address,
                             $signed(want.accumulator_value), $signed(want.addressed_word),
                             want.write_out, want.status);
                    $display("  got  %0d %0d %0d %0d %0d %0d", got.opcode, got.address,
                             $signed(got.accumulator_value), $signed(got.addressed_word),
                             got.write_out, got.status);
                end
            end
        endfunction

        function int pending();
            return owed_results.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   steady_phase;

    ame_result_board board = new();

    ame_in_if  in_ch ();
    ame_out_if out_ch ();

    accumulator_machine_executor_unit #(
        .WORD_BITS(32)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit, far above the slowest legal run
    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Result receiver: stalls about a quarter of the time outside the steady stretch
    always @(posedge i_clk) begin
        if (!i_rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= steady_phase || ($urandom_range(99) >= 25);
    end

    // Monitor both channels for completed transfers
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready)
                board.check_result('{out_ch.opcode, out_ch.address, out_ch.accumulator_value,
                                     out_ch.addressed_word, out_ch.write_out,
                                     t_status'(out_ch.status)});
            if (in_ch.valid && in_ch.ready)
                board.note_instruction(in_ch.instruction, in_ch.entered_word);
        end
    end

    // Offer one instruction, with random gaps first, and wait for its transfer
    task automatic send_instruction(input logic [INSTR_BITS-1:0] instr,
                                    input logic [ENTRY_BITS-1:0] word);
        while (!steady_phase && $urandom_range(99) < 25) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.instruction <= instr;
        in_ch.entered_word <= word;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_op(input logic [FIELD_BITS-1:0] op, input int unsigned addr,
                           input logic [ENTRY_BITS-1:0] word);
        send_instruction(INSTR_BITS'(op * DEC_BASE + addr), word);
    endtask

    function automatic logic [FIELD_BITS-1:0] random_opcode();
        case ($urandom_range(8))
            0:       return OP_READ;
            1:       return OP_WRITE;
            2:       return OP_LOAD;
            3:       return OP_STORE;
            4:       return OP_ADD;
            5:       return OP_SUB;
            6:       return OP_DIVIDE;
            7:       return OP_MULT;
            default: return OP_CLEAR;
        endcase
    endfunction

    // Data words: extremes, small signed values and full-range noise
    function automatic logic [ENTRY_BITS-1:0] random_word();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'(int'($urandom_range(400)) - 200);
            default: return $urandom;
        endcase
    endfunction

    // Stimulus
    initial begin
        int unsigned addr;
        in_ch.valid <= 1'b0;
        in_ch.instruction <= '0;
        in_ch.entered_word <= '0;
        i_rst_n <= 1'b0;
        steady_phase = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, every opcode, wrap cases, zero divisor, bad opcodes
        send_op(OP_READ, 0, 32'h8000_0000);
        send_op(OP_READ, 99, 32'h7FFF_FFFF);
        send_op(OP_READ, 1, 32'hFFFF_FFFF);
        send_op(OP_LOAD, 0, '0);
        send_op(OP_DIVIDE, 1, '0);             // most negative over minus one
        send_op(OP_DIVIDE, 2, '0);             // never-written word is zero
        send_op(OP_ADD, 99, '0);
        send_op(OP_SUB, 0, '0);                // reaches the most positive value
        send_op(OP_MULT, 99, '0);
        send_op(OP_WRITE, 99, 32'h1234_5678);
        send_op(OP_STORE, 5, '0);
        send_op(OP_LOAD, 5, '0);
        send_op(OP_READ, 7, 32'(-7));
        send_op(OP_DIVIDE, 7, '0);             // truncation toward zero
        send_op(OP_MULT, 1, '0);
        send_op(OP_CLEAR, 0, 32'hFFFF_FFFF);
        send_op(OP_STORE, 98, '0);
        send_instruction(14'd0, 32'hFFFF_FFFF);
        send_instruction(14'd9999, '0);
        send_instruction(14'd10000, '0);       // past the decimal range
        send_instruction(14'd16383, 32'h8000_0000);

        // Random programs with some raw instruction noise
        for (int n = 0; n < 1100; n++) begin
            steady_phase = (n >= 500 && n < 700);
            if ($urandom_range(99) < 10) begin
                send_instruction(INSTR_BITS'($urandom_range(16383)), $urandom);
            end else begin
                addr = ($urandom_range(3) == 0) ? $urandom_range(99) : $urandom_range(15);
                send_op(random_opcode(), addr, random_word());
            end
        end
        steady_phase = 1'b0;
        in_ch.valid <= 1'b0;

        // Drain, then allow stray results to show up
        while (board.pending() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (board.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* accumulator_machine_executor_unit.f */
+incdir+rtl/core
rtl/core/ame_pkg.sv
rtl/core/ame_channels.sv
rtl/core/ame_muldiv.sv
rtl/core/ame_ctrl.sv
rtl/core/ame_dp.sv
rtl/core/accumulator_machine_executor_unit.sv
sim/accumulator_machine_executor_unit_tb.sv
